### rtl/core/pgf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pgf_pkg
// Shared widths, register indexes and interface structs of the grid factorizer
// -----------------------------------------------------------------------------
package pgf_pkg;

	localparam int CNT_W     = 16;
	localparam int AREA_W    = 2 * CNT_W;
	localparam int ASUM_W    = AREA_W + 2;
	localparam int MA_W      = ASUM_W;
	localparam int PROD_W    = MA_W + CNT_W;
	localparam int SURF_W    = PROD_W + 1;
	localparam int DIV_CNT_W = $clog2(CNT_W + 1);
	localparam int IDX_W     = 8;
	localparam int CFG_W     = 16;

	localparam logic [IDX_W-1:0] REG_PROC_COUNT = 8'd0;
	localparam logic [IDX_W-1:0] REG_TWO_DIM    = 8'd1;

	typedef struct packed {
		logic              start;
		logic [CNT_W-1:0]  dividend;
		logic [AREA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] quotient;
		logic [CNT_W-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

### rtl/core/pgf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pgf_mul
// Shared multiplier with registered product
// -----------------------------------------------------------------------------
module pgf_mul (
	input  wire logic                       clk,
	input  wire logic [pgf_pkg::MA_W-1:0]   a,
	input  wire logic [pgf_pkg::CNT_W-1:0]  b,
	output logic      [pgf_pkg::PROD_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= pgf_pkg::PROD_W'(a) * pgf_pkg::PROD_W'(b);
	end

endmodule
`default_nettype wire

### rtl/core/pgf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pgf_div
// Shared restoring divider, one quotient bit per cycle
// -----------------------------------------------------------------------------
module pgf_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pgf_pkg::div_req_t req,
	output pgf_pkg::div_rsp_t      rsp
);

	logic [pgf_pkg::CNT_W-1:0]     quo_q;
	logic [pgf_pkg::CNT_W-1:0]     rem_q;
	logic [pgf_pkg::AREA_W-1:0]    den_q;
	logic [pgf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pgf_pkg::CNT_W:0]       shifted;
	logic [pgf_pkg::AREA_W-1:0]    shifted_ext;
	logic                          ge;
	logic [pgf_pkg::AREA_W-1:0]    diff;

	assign shifted     = {rem_q, quo_q[pgf_pkg::CNT_W-1]};
	assign shifted_ext = pgf_pkg::AREA_W'(shifted);
	assign ge          = shifted_ext >= den_q;
	assign diff        = shifted_ext - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= pgf_pkg::DIV_CNT_W'(pgf_pkg::CNT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == pgf_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[pgf_pkg::CNT_W-2:0], ge};
			rem_q <= ge ? diff[pgf_pkg::CNT_W-1:0] : shifted[pgf_pkg::CNT_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

### rtl/core/processor_grid_factorizer.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// processor_grid_factorizer
// Least-surface split of the processor count into a 3-D processor grid
// -----------------------------------------------------------------------------
// Input beats on s_axis carry grid cell counts and requested processor counts
// per axis (0 = free). Each input beat yields one output beat on m_axis with
// procs_x/y/z in tdata and the found flag in tuser. The cfg channel writes
// processor_count (index 0) and two_dimensional (index 1); it is always ready
// and must only be used while the block is idle.
// One item at a time: s_axis_tready is high only while the sequencer idles.
// All three counts requested: the counts pass straight through. Two requested:
// one multiply and one division. Search: set-up of the areas and the bound,
// then one division per tried x divisor and one per tried y divisor, since every
// trial goes through the single shared 1-bit-per-cycle divider; the multiplier
// is shared by the count, area, bound and surface products.
// The result sits in an output register, so a stalled receiver only holds the
// finished beat; the next input beat is still taken and worked on, and its
// result waits until the register is free.
// Reset clears the sequencer and output valid and sets processor_count to 1,
// two_dimensional to 0.
// -----------------------------------------------------------------------------
module processor_grid_factorizer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// cells_x, cells_y, cells_z, want_x, want_y, want_z
	input  wire logic [6*pgf_pkg::CNT_W-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// procs_x, procs_y, procs_z
	output logic [3*pgf_pkg::CNT_W-1:0]     m_axis_tdata,
	// found
	output logic                            m_axis_tuser,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [pgf_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [pgf_pkg::CFG_W-1:0]  cfg_data
);

	localparam int CW = pgf_pkg::CNT_W;

	typedef enum logic [18:0] {
		ST_IDLE = 19'h00001,
		ST_PMUL = 19'h00002,
		ST_PST  = 19'h00004,
		ST_PDIV = 19'h00008,
		ST_AXY  = 19'h00010,
		ST_AXZ  = 19'h00020,
		ST_AYZ  = 19'h00040,
		ST_ASUM = 19'h00080,
		ST_ABST = 19'h00100,
		ST_ABW  = 19'h00200,
		ST_XTST = 19'h00400,
		ST_XDIV = 19'h00800,
		ST_YTST = 19'h01000,
		ST_YDIV = 19'h02000,
		ST_SF0  = 19'h04000,
		ST_SF1  = 19'h08000,
		ST_SF2  = 19'h10000,
		ST_SF3  = 19'h20000,
		ST_DONE = 19'h40000
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0]              n_q;
	logic                       two_d_q;
	logic [CW-1:0]              cx_q, cy_q, cz_q, wx_q, wy_q, wz_q;
	logic [pgf_pkg::AREA_W-1:0] axy_q, axz_q, ayz_q;
	logic [pgf_pkg::ASUM_W-1:0] asum_q;
	logic [pgf_pkg::SURF_W-1:0] best_q;
	logic [pgf_pkg::PROD_W-1:0] acc_q;
	logic [CW:0]                ix_q, iy_q;
	logic [CW-1:0]              rem_q, iz_q;
	logic [CW-1:0]              rx_q, ry_q, rz_q;
	logic                       fnd_q;
	logic                       m_valid_q;
	logic [3*CW-1:0]            m_data_q;
	logic                       m_user_q;

	logic                       in_beat;
	logic                       out_free;
	logic                       last_x;
	logic                       single_y;
	logic                       y_reject;
	state_t                     after_x;
	state_t                     after_y;
	logic [CW-1:0]              in_cx, in_cy, in_cz, in_wx, in_wy, in_wz;
	logic [1:0]                 n_given;
	logic [pgf_pkg::MA_W-1:0]   mul_a;
	logic [CW-1:0]              mul_b;
	logic [pgf_pkg::PROD_W-1:0] mul_p;
	pgf_pkg::div_req_t          div_req;
	pgf_pkg::div_rsp_t          div_rsp;
	logic [pgf_pkg::SURF_W-1:0] surf;

	assign in_cx = s_axis_tdata[0*CW +: CW];
	assign in_cy = s_axis_tdata[1*CW +: CW];
	assign in_cz = s_axis_tdata[2*CW +: CW];
	assign in_wx = s_axis_tdata[3*CW +: CW];
	assign in_wy = s_axis_tdata[4*CW +: CW];
	assign in_wz = s_axis_tdata[5*CW +: CW];

	assign n_given = 2'(in_wx != '0) + 2'(in_wy != '0) + 2'(in_wz != '0);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	assign last_x   = (wx_q != '0);
	assign single_y = (wy_q != '0) || two_d_q;
	assign after_x  = last_x ? ST_DONE : ST_XTST;
	assign after_y  = single_y ? after_x : ST_YTST;
	assign y_reject = (div_rsp.remainder != '0)
		|| ((wz_q != '0) && (div_rsp.quotient != wz_q))
		|| (two_d_q && (div_rsp.quotient != CW'(1)));

	assign surf = pgf_pkg::SURF_W'(acc_q) + pgf_pkg::SURF_W'(mul_p);

	pgf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	pgf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PMUL: begin
				if (wy_q != '0 && wz_q != '0) begin
					mul_a = pgf_pkg::MA_W'(wy_q);
					mul_b = wz_q;
				end else if (wx_q != '0 && wz_q != '0) begin
					mul_a = pgf_pkg::MA_W'(wx_q);
					mul_b = wz_q;
				end else begin
					mul_a = pgf_pkg::MA_W'(wx_q);
					mul_b = wy_q;
				end
			end
			ST_AXY: begin
				mul_a = pgf_pkg::MA_W'(cx_q);
				mul_b = cy_q;
			end
			ST_AXZ: begin
				mul_a = pgf_pkg::MA_W'(cx_q);
				mul_b = cz_q;
			end
			ST_AYZ: begin
				mul_a = pgf_pkg::MA_W'(cy_q);
				mul_b = cz_q;
			end
			ST_ABST: begin
				mul_a = asum_q;
				mul_b = n_q;
			end
			ST_SF0: begin
				mul_a = pgf_pkg::MA_W'(ayz_q);
				mul_b = ix_q[CW-1:0];
			end
			ST_SF1: begin
				mul_a = pgf_pkg::MA_W'(axz_q);
				mul_b = iy_q[CW-1:0];
			end
			ST_SF2: begin
				mul_a = pgf_pkg::MA_W'(axy_q);
				mul_b = iz_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = n_q;
		div_req.divisor  = pgf_pkg::AREA_W'(ix_q);
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					if (n_given == 2'd3)
						state_d = ST_DONE;
					else if (n_given == 2'd2)
						state_d = ST_PMUL;
					else
						state_d = ST_AXY;
				end
			end
			ST_PMUL: state_d = ST_PST;
			ST_PST: begin
				div_req.start   = 1'b1;
				div_req.divisor = mul_p[pgf_pkg::AREA_W-1:0];
				state_d         = ST_PDIV;
			end
			ST_PDIV: begin
				if (div_rsp.done)
					state_d = ST_DONE;
			end
			ST_AXY:  state_d = ST_AXZ;
			ST_AXZ:  state_d = ST_AYZ;
			ST_AYZ:  state_d = ST_ASUM;
			ST_ASUM: state_d = ST_ABST;
			ST_ABST: state_d = ST_ABW;
			ST_ABW:  state_d = ST_XTST;
			ST_XTST: begin
				if (ix_q > {1'b0, n_q}) begin
					state_d = ST_DONE;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_XDIV;
				end
			end
			ST_XDIV: begin
				if (div_rsp.done)
					state_d = (div_rsp.remainder != '0) ? after_x : ST_YTST;
			end
			ST_YTST: begin
				if (iy_q > {1'b0, rem_q}) begin
					state_d = after_x;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = rem_q;
					div_req.divisor  = pgf_pkg::AREA_W'(iy_q);
					state_d          = ST_YDIV;
				end
			end
			ST_YDIV: begin
				if (div_rsp.done)
					state_d = y_reject ? after_y : ST_SF0;
			end
			ST_SF0: state_d = ST_SF1;
			ST_SF1: state_d = ST_SF2;
			ST_SF2: state_d = ST_SF3;
			ST_SF3: state_d = after_y;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= CW'(1);
			two_d_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pgf_pkg::REG_PROC_COUNT)
					n_q <= cfg_data[CW-1:0];
				else if (cfg_index == pgf_pkg::REG_TWO_DIM)
					two_d_q <= cfg_data[0];
			end
			if (state_q == ST_DONE && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cx_q  <= in_cx;
			cy_q  <= in_cy;
			cz_q  <= in_cz;
			wx_q  <= in_wx;
			wy_q  <= in_wy;
			wz_q  <= in_wz;
			rx_q  <= in_wx;
			ry_q  <= in_wy;
			rz_q  <= in_wz;
			fnd_q <= (n_given == 2'd3);
			ix_q  <= (in_wx != '0) ? {1'b0, in_wx} : (CW+1)'(1);
		end
		case (state_q)
			ST_PDIV: begin
				if (div_rsp.done) begin
					fnd_q <= 1'b1;
					if (wy_q != '0 && wz_q != '0)
						rx_q <= div_rsp.quotient;
					else if (wx_q != '0 && wz_q != '0)
						ry_q <= div_rsp.quotient;
					else
						rz_q <= div_rsp.quotient;
				end
			end
			ST_AXZ: axy_q <= mul_p[pgf_pkg::AREA_W-1:0];
			ST_AYZ: axz_q <= mul_p[pgf_pkg::AREA_W-1:0];
			ST_ASUM: begin
				ayz_q  <= mul_p[pgf_pkg::AREA_W-1:0];
				asum_q <= pgf_pkg::ASUM_W'(axy_q) + pgf_pkg::ASUM_W'(axz_q)
					+ pgf_pkg::ASUM_W'(mul_p[pgf_pkg::AREA_W-1:0]);
			end
			ST_ABW: best_q <= {mul_p, 1'b0};
			ST_XDIV: begin
				if (div_rsp.done && div_rsp.remainder == '0) begin
					rem_q <= div_rsp.quotient;
					if (wy_q != '0)
						iy_q <= {1'b0, wy_q};
					else if (two_d_q)
						iy_q <= {1'b0, div_rsp.quotient};
					else
						iy_q <= (CW+1)'(1);
				end
			end
			ST_YDIV: begin
				if (div_rsp.done)
					iz_q <= div_rsp.quotient;
			end
			ST_SF1: acc_q <= mul_p;
			ST_SF2: acc_q <= acc_q + mul_p;
			ST_SF3: begin
				if (surf < best_q) begin
					best_q <= surf;
					rx_q   <= ix_q[CW-1:0];
					ry_q   <= iy_q[CW-1:0];
					rz_q   <= iz_q;
					fnd_q  <= 1'b1;
				end
			end
			default: ;
		endcase
		// step to the next candidate divisor
		if (state_d == ST_XTST && state_q != ST_ABW)
			ix_q <= ix_q + 1'b1;
		if (state_d == ST_YTST && (state_q == ST_YDIV || state_q == ST_SF3))
			iy_q <= iy_q + 1'b1;
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= {rz_q, ry_q, rx_q};
			m_user_q <= fnd_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_PDIV || state_q == ST_XDIV || state_q == ST_YDIV))
		else $error("divider result with no waiting state");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SF3) |=> (best_q <= $past(best_q)))
		else $error("best surface grew during search");

	a_trial_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XTST || state_q == ST_YTST) |-> (ix_q != '0 && iy_q != '0
			|| state_q == ST_XTST && ix_q != '0))
		else $error("zero trial divisor");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
		else $error("finished result not presented");

endmodule
`default_nettype wire
